FILE: rtl/mandelbrot_escape_time_pixel_defines.svh
// assertion helpers shared by the rtl
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/mbet_pkg.sv
`timescale 1ns / 1ps
package mbet_pkg;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 10;
    localparam int COLOR_W = 24;
    localparam int ITER_W  = 13;
    localparam int ESCL_W  = 31;
    localparam int CRD_W   = 32;
    localparam int PROD_W  = 2 * CRD_W;

    typedef logic signed [CRD_W-1:0]  t_coord;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MCA,
        ST_MCB,
        ST_LOAD,
        ST_ITP,
        ST_ITR,
        ST_ITI,
        ST_ITC,
        ST_COLW,
        ST_COLR,
        ST_FIN
    } t_state;

    localparam logic [2:0] REG_VIEW_LEFT  = 3'd0;
    localparam logic [2:0] REG_VIEW_TOP   = 3'd1;
    localparam logic [2:0] REG_STEP_REAL  = 3'd2;
    localparam logic [2:0] REG_STEP_IMAG  = 3'd3;
    localparam logic [2:0] REG_COLOR_SCL  = 3'd4;
    localparam logic [2:0] REG_ITER_MAX   = 3'd5;
    localparam logic [2:0] REG_ESC_LIMIT  = 3'd6;

    localparam t_coord               RST_VIEW_LEFT = -32'sd536870912;
    localparam t_coord               RST_VIEW_TOP  = -32'sd402653184;
    localparam t_coord               RST_STEP_REAL = 32'sd786432;
    localparam t_coord               RST_STEP_IMAG = 32'sd786432;
    localparam logic [COLOR_W-1:0]   RST_COLOR_SCL = 24'd16777215;
    localparam logic [ITER_W-1:0]    RST_ITER_MAX  = 13'd64;
    localparam logic [ESCL_W-1:0]    RST_ESC_LIMIT = 31'd1073741824;

endpackage

FILE: rtl/mbet_mul.sv
`timescale 1ns / 1ps
module mbet_mul import mbet_pkg::*; (
    input  logic   i_clk,
    input  t_coord i_a,
    input  t_coord i_b,
    output t_prod  o_prod
);

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/mbet_div.sv
`timescale 1ns / 1ps
module mbet_div import mbet_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COLOR_W-1:0] i_dividend,
    input  logic [ITER_W-1:0]  i_divisor,
    output logic               o_done,
    output logic [COLOR_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(COLOR_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [ITER_W-1:0]  r_rem;
    logic [ITER_W-1:0]  r_div;
    logic [COLOR_W-1:0] r_quot;

    logic [ITER_W:0]    w_shift;
    logic [ITER_W+1:0]  w_trial;

    assign w_shift = {r_rem, r_quot[COLOR_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(COLOR_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // one restoring step per cycle, dividend shifted out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            if (!w_trial[ITER_W+1]) begin
                r_rem  <= w_trial[ITER_W-1:0];
                r_quot <= {r_quot[COLOR_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_shift[ITER_W-1:0];
                r_quot <= {r_quot[COLOR_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: rtl/mandelbrot_escape_time_pixel.sv
`timescale 1ns / 1ps
// mandelbrot escape-time evaluator for one pixel
// input beat on s_axis: pixel column and row. the point c is formed from the
// view registers, then z = z^2 + c is iterated from zero until |z|^2 exceeds
// escape_limit_sq or the iteration limit is reached.
// output beat on m_axis: column, row, colour, iteration index and escaped flag.
// registers are written over the apb port; the user must write them only while no pixel
// is in flight, as the block itself does not enforce this. setup runs through ST_MCA and
// ST_MCB, which drive the one 32x32 multiplier to form c, and ST_LOAD; each iteration
// then steps through ST_ITP, ST_ITR and ST_ITI, which drive the multiplier, and ST_ITC,
// which runs the escape test. an escaping pixel then passes through ST_COLW, ST_COLR and
// ST_FIN to scale the colour and load the output register, ST_COLW waiting for a serial
// divider that is started at the input beat. s_axis_tready is high only between pixels,
// so the next input beat can be taken in the cycle in which output valid rises.
// the output register holds one result, so a new pixel is taken while a
// result waits; a stalled receiver holds the next result in its final state.
// reset restores the default view and clears all handshake state.
`include "mandelbrot_escape_time_pixel_defines.svh"
module mandelbrot_escape_time_pixel import mbet_pkg::*; #(
    parameter int ROWS          = 1024,
    parameter int FRACTION_BITS = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // column, row
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_column, out_row, color, iterations, escaped
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SH_RE = FRACTION_BITS;
    localparam int SH_IM = FRACTION_BITS - 1;
    localparam logic signed [PROD_W:0] SAT_MAX = (PROD_W+1)'(64'sd2147483647);
    localparam logic signed [PROD_W:0] SAT_MIN = (PROD_W+1)'(-64'sd2147483648);

    function automatic t_coord f_sat(input logic signed [PROD_W:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[CRD_W-1:0];
        end else if (v < SAT_MIN) begin
            return SAT_MIN[CRD_W-1:0];
        end
        return v[CRD_W-1:0];
    endfunction

    t_coord             r_view_left;
    t_coord             r_view_top;
    t_coord             r_step_re;
    t_coord             r_step_im;
    logic [COLOR_W-1:0] r_color_scl;
    logic [ITER_W-1:0]  r_lim;
    logic [ESCL_W-1:0]  r_esc_lim;

    t_state             r_state;
    t_state             n_state;

    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    t_coord             r_ca;
    t_coord             r_cb;
    t_coord             r_zr;
    t_coord             r_zi;
    t_prod              r_sqr;
    t_prod              r_sqi;
    logic [ITER_W-1:0]  r_iter;
    logic [ITER_W-1:0]  r_res_iters;
    logic               r_res_esc;
    logic [COLOR_W-1:0] r_res_color;

    logic               r_out_valid;
    logic [COL_W-1:0]   r_out_col;
    logic [ROW_W-1:0]   r_out_row;
    logic [COLOR_W-1:0] r_out_color;
    logic [ITER_W-1:0]  r_out_iters;
    logic               r_out_esc;

    logic               w_cfg_wr;
    logic               w_accept;
    logic               w_out_load;
    logic               w_div_start;
    logic               w_div_done;
    logic [COLOR_W-1:0] w_quot;
    t_coord             w_mul_a;
    t_coord             w_mul_b;
    t_prod              w_prod;
    t_coord             w_rowoff;
    t_prod              w_diff;
    t_coord             w_nr;
    t_coord             w_ni;
    t_coord             w_ca;
    t_coord             w_cb;
    logic [PROD_W-1:0]  w_mag_sum;
    logic [PROD_W-1:0]  w_mag;
    logic               w_esc;
    logic               w_last;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_left <= RST_VIEW_LEFT;
            r_view_top  <= RST_VIEW_TOP;
            r_step_re   <= RST_STEP_REAL;
            r_step_im   <= RST_STEP_IMAG;
            r_color_scl <= RST_COLOR_SCL;
            r_lim       <= RST_ITER_MAX;
            r_esc_lim   <= RST_ESC_LIMIT;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                REG_VIEW_LEFT: r_view_left <= pwdata;
                REG_VIEW_TOP:  r_view_top  <= pwdata;
                REG_STEP_REAL: r_step_re   <= pwdata;
                REG_STEP_IMAG: r_step_im   <= pwdata;
                REG_COLOR_SCL: r_color_scl <= pwdata[COLOR_W-1:0];
                REG_ITER_MAX:  r_lim       <= pwdata[ITER_W-1:0];
                REG_ESC_LIMIT: r_esc_lim   <= pwdata[ESCL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_VIEW_LEFT: prdata = $unsigned(r_view_left);
            REG_VIEW_TOP:  prdata = $unsigned(r_view_top);
            REG_STEP_REAL: prdata = $unsigned(r_step_re);
            REG_STEP_IMAG: prdata = $unsigned(r_step_im);
            REG_COLOR_SCL: prdata = 32'(r_color_scl);
            REG_ITER_MAX:  prdata = 32'(r_lim);
            REG_ESC_LIMIT: prdata = 32'(r_esc_lim);
            default:       prdata = '0;
        endcase
    end

    // shared units
    mbet_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    mbet_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_color_scl),
        .i_divisor  (r_lim),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // datapath arithmetic
    assign w_rowoff  = CRD_W'(ROWS - 1) - t_coord'({{(CRD_W-ROW_W){1'b0}}, r_row});
    assign w_diff    = r_sqr - r_sqi;
    assign w_nr      = f_sat((PROD_W+1)'(w_diff >>> SH_RE) + (PROD_W+1)'(r_ca));
    assign w_ni      = f_sat((PROD_W+1)'(w_prod >>> SH_IM) + (PROD_W+1)'(r_cb));
    assign w_ca      = f_sat((PROD_W+1)'(w_prod) + (PROD_W+1)'(r_view_left));
    assign w_cb      = f_sat((PROD_W+1)'(w_prod) + (PROD_W+1)'(r_view_top));
    assign w_mag_sum = $unsigned(r_sqr) + $unsigned(w_prod);
    assign w_mag     = w_mag_sum >> FRACTION_BITS;
    assign w_esc     = w_mag > PROD_W'(r_esc_lim);
    assign w_last    = (r_iter + 1'b1) == r_lim;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_load = (r_state == ST_FIN) && (!r_out_valid || m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_MCA;
                end
            end
            ST_MCA:  n_state = ST_MCB;
            ST_MCB:  n_state = ST_LOAD;
            ST_LOAD: begin
                if (r_lim == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_ITP;
                end
            end
            ST_ITP:  n_state = ST_ITR;
            ST_ITR:  n_state = ST_ITI;
            ST_ITI:  n_state = ST_ITC;
            ST_ITC: begin
                if (w_esc) begin
                    n_state = ST_COLW;
                end else if (w_last) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_ITP;
                end
            end
            ST_COLW: begin
                if (w_div_done) begin
                    n_state = ST_COLR;
                end
            end
            ST_COLR: n_state = ST_FIN;
            ST_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_mul_a       = '0;
        w_mul_b       = '0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_div_start   = s_axis_tvalid;
            end
            ST_MCA: begin
                w_mul_a = t_coord'({{(CRD_W-COL_W){1'b0}}, r_col});
                w_mul_b = r_step_re;
            end
            ST_MCB: begin
                w_mul_a = w_rowoff;
                w_mul_b = r_step_im;
            end
            ST_ITP: begin
                w_mul_a = r_zr;
                w_mul_b = r_zi;
            end
            ST_ITR: begin
                w_mul_a = r_zr;
                w_mul_b = r_zr;
            end
            ST_ITI: begin
                w_mul_a = r_zi;
                w_mul_b = r_zi;
            end
            ST_COLW: begin
                w_mul_a = t_coord'({{(CRD_W-COLOR_W){1'b0}}, w_quot});
                w_mul_b = t_coord'({{(CRD_W-ITER_W){1'b0}}, r_iter});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // iteration registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_col <= s_axis_tdata[COL_W-1:0];
                    r_row <= s_axis_tdata[COL_W+ROW_W-1:COL_W];
                end
            end
            ST_MCB: begin
                r_ca <= w_ca;
            end
            ST_LOAD: begin
                r_cb        <= w_cb;
                r_zr        <= '0;
                r_zi        <= '0;
                r_sqr       <= '0;
                r_sqi       <= '0;
                r_iter      <= '0;
                r_res_iters <= '0;
                r_res_esc   <= 1'b0;
                r_res_color <= '0;
            end
            ST_ITP: begin
                r_zr <= w_nr;
            end
            ST_ITR: begin
                r_zi <= w_ni;
            end
            ST_ITI: begin
                r_sqr <= w_prod;
            end
            ST_ITC: begin
                r_sqi <= w_prod;
                if (w_esc) begin
                    r_res_esc   <= 1'b1;
                    r_res_iters <= r_iter;
                end else if (w_last) begin
                    r_res_iters <= r_lim;
                end else begin
                    r_iter <= r_iter + 1'b1;
                end
            end
            ST_COLR: begin
                r_res_color <= w_prod[COLOR_W-1:0];
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_col   <= r_col;
            r_out_row   <= r_row;
            r_out_color <= r_res_color;
            r_out_iters <= r_res_iters;
            r_out_esc   <= r_res_esc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_esc, r_out_iters, r_out_color, r_out_row, r_out_col};

    `ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == ST_MCA)
    `ASSERT_IMP(a_iter_in_range, i_clk, i_rst_n,
        r_state == ST_ITP || r_state == ST_ITR || r_state == ST_ITI || r_state == ST_ITC,
        r_iter < r_lim)
    `ASSERT_IMP(a_esc_index_below_limit, i_clk, i_rst_n, r_out_valid && r_out_esc,
        r_out_iters < r_lim)
    `ASSERT_IMP(a_no_esc_black, i_clk, i_rst_n, r_out_valid && !r_out_esc,
        r_out_color == '0 && r_out_iters == r_lim)

endmodule

FILE: verif/mandelbrot_escape_time_pixel_test.sv
`timescale 1ns / 1ps
module mandelbrot_escape_time_pixel_test import mbet_pkg::*;;

    localparam int PIXEL_ROWS   = 1024;
    localparam int FRAC_BITS    = 28;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 2000;
    localparam int CYCLE_LIMIT  = 1500000;

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [COLOR_W-1:0] color;
        logic [ITER_W-1:0]  iters;
        logic               escaped;
    } t_pixel_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // column, row
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;   // out_column, out_row, color, iterations, escaped
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // register values as last written
    t_coord             set_left;
    t_coord             set_top;
    t_coord             set_step_re;
    t_coord             set_step_im;
    logic [COLOR_W-1:0] set_color_scale;
    logic [ITER_W-1:0]  set_iter_max;
    logic [ESCL_W-1:0]  set_escape_sq;

    t_pixel_result expected_pixels[$];
    int            error_count   = 0;
    int            send_idle_pct = 0;
    int            stall_pct     = 0;
    bit            hold_on       = 1'b0;
    int            stall_count   = 0;
    int            cycle_count   = 0;

    mandelbrot_escape_time_pixel #(
        .ROWS(PIXEL_ROWS),
        .FRACTION_BITS(FRAC_BITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_pixel_result predict_pixel(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
        longint        row_off, c_re, c_im, zr, zi, nr, ni;
        t_u64          mag, limit, k, color64;
        t_pixel_result r;
        row_off = longint'(PIXEL_ROWS - 1) - longint'(row);
        c_re    = clamp32(longint'(set_left) + longint'(col) * longint'(set_step_re));
        c_im    = clamp32(longint'(set_top) + row_off * longint'(set_step_im));
        zr      = 0;
        zi      = 0;
        limit   = t_u64'(set_iter_max);
        r.col     = col;
        r.row     = row;
        r.color   = '0;
        r.iters   = set_iter_max;
        r.escaped = 1'b0;
        for (k = 0; k < limit; k++) begin
            nr  = clamp32(((zr * zr - zi * zi) >>> FRAC_BITS) + c_re);
            ni  = clamp32(((zr * zi) >>> (FRAC_BITS - 1)) + c_im);
            mag = ($unsigned(nr * nr) + $unsigned(ni * ni)) >> FRAC_BITS;
            if (mag > t_u64'(set_escape_sq)) begin
                color64   = (t_u64'(set_color_scale) / limit) * k;
                r.color   = color64[COLOR_W-1:0];
                r.iters   = k[ITER_W-1:0];
                r.escaped = 1'b1;
                break;
            end
            zr = nr;
            zi = ni;
        end
        return r;
    endfunction

    task automatic report_failure(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input t_u64 got, input t_u64 want,
                               input t_pixel_result px);
        if (got !== want)
            report_failure($sformatf("%s of pixel (%0d,%0d): got %0d, expected %0d",
                                     name, px.col, px.row, got, want));
    endtask

    always @(posedge i_clk) begin : check_results
        t_pixel_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                report_failure($sformatf("result beat with nothing expected, data %h",
                                         m_axis_tdata));
            end else begin
                want = expected_pixels.pop_front();
                check_field("column", m_axis_tdata[9:0], want.col, want);
                check_field("row", m_axis_tdata[19:10], want.row, want);
                check_field("colour", m_axis_tdata[43:20], want.color, want);
                check_field("iterations", m_axis_tdata[56:44], want.iters, want);
                check_field("escaped", m_axis_tdata[57], want.escaped, want);
            end
        end
    end

    // receiver: random stalls, plus one long hold counted here
    always @(negedge i_clk) begin
        if (!hold_on)
            stall_count <= 0;
        else if (stall_count < LONG_HOLD)
            stall_count <= stall_count + 1;
        m_axis_tready <= !(hold_on && stall_count < LONG_HOLD) &&
                         ($urandom_range(99) >= stall_pct);
    end

    task automatic store_setting(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            REG_VIEW_LEFT: set_left        = value;
            REG_VIEW_TOP:  set_top         = value;
            REG_STEP_REAL: set_step_re     = value;
            REG_STEP_IMAG: set_step_im     = value;
            REG_COLOR_SCL: set_color_scale = value[COLOR_W-1:0];
            REG_ITER_MAX:  set_iter_max    = value[ITER_W-1:0];
            REG_ESC_LIMIT: set_escape_sq   = value[ESCL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        store_setting(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input t_coord left, input t_coord top,
                             input t_coord step_re, input t_coord step_im,
                             input logic [COLOR_W-1:0] color_scale,
                             input logic [ITER_W-1:0] iter_max,
                             input logic [ESCL_W-1:0] escape_sq);
        drain_results();
        apb_write(REG_VIEW_LEFT, left);
        apb_write(REG_VIEW_TOP, top);
        apb_write(REG_STEP_REAL, step_re);
        apb_write(REG_STEP_IMAG, step_im);
        apb_write(REG_COLOR_SCL, {8'd0, color_scale});
        apb_write(REG_ITER_MAX, {19'd0, iter_max});
        apb_write(REG_ESC_LIMIT, {1'b0, escape_sq});
    endtask

    // only called with the input side drained
    task automatic set_traffic(input int send_pct, input int recv_pct, input bit hold);
        @(posedge i_clk);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        hold_on       = hold;
        @(negedge i_clk);
    endtask

    task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, row, col};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_pixels.push_back(predict_pixel(col, row));
        @(negedge i_clk);
    endtask

    task automatic send_random_pixel();
        send_pixel($urandom_range(1023), $urandom_range(1023));
    endtask

    task automatic test_default_view();
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd682, 10'd511);
        send_pixel(10'd341, 10'd682);
        drain_results();
    endtask

    task automatic test_iteration_limits();
        // zero limit: no step runs
        configure(RST_VIEW_LEFT, RST_VIEW_TOP, RST_STEP_REAL, RST_STEP_IMAG,
                  RST_COLOR_SCL, 13'd0, RST_ESC_LIMIT);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd700, 10'd500);
        // single step, zero threshold
        configure(RST_VIEW_LEFT, RST_VIEW_TOP, RST_STEP_REAL, RST_STEP_IMAG,
                  RST_COLOR_SCL, 13'd1, 31'd0);
        send_pixel(10'd5, 10'd900);
        send_pixel(10'd682, 10'd511);
        // c = 0 never escapes, limits beyond the usual range
        configure(32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'hFFFFFF, 13'h1FFF, 31'd0);
        send_pixel(10'd1023, 10'd0);
        configure(32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd12345, 13'd4096, RST_ESC_LIMIT);
        send_pixel(10'd512, 10'd512);
        // widest threshold
        configure(RST_VIEW_LEFT, RST_VIEW_TOP, RST_STEP_REAL, RST_STEP_IMAG,
                  RST_COLOR_SCL, 13'd100, 31'h7FFFFFFF);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd600, 10'd300);
        drain_results();
    endtask

    task automatic test_saturation();
        configure(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                  24'd0, 13'd64, 31'h7FFFFFFF);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        configure(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                  24'hFFFFFF, 13'd16, RST_ESC_LIMIT);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        drain_results();
    endtask

    task automatic randomise_settings();
        t_coord             left, top, step_re, step_im;
        logic [COLOR_W-1:0] color_scale;
        logic [ITER_W-1:0]  iter_max;
        logic [ESCL_W-1:0]  escape_sq;
        if ($urandom_range(3) == 0) begin
            left    = $urandom();
            top     = $urandom();
            step_re = $urandom();
            step_im = $urandom();
        end else begin
            left    = -t_coord'($urandom_range(0, 805306368));
            top     = -t_coord'($urandom_range(0, 402653184));
            step_re = $urandom_range(1, 1048576);
            step_im = $urandom_range(1, 1048576);
            if ($urandom_range(3) == 0)
                step_re = -step_re;
            if ($urandom_range(3) == 0)
                step_im = -step_im;
        end
        color_scale = $urandom_range(0, 24'hFFFFFF);
        iter_max    = ($urandom_range(15) == 0) ? 13'd0 : ITER_W'($urandom_range(1, 80));
        escape_sq   = ($urandom_range(3) == 0) ? ESCL_W'($urandom() >> 1) : RST_ESC_LIMIT;
        configure(left, top, step_re, step_im, color_scale, iter_max, escape_sq);
    endtask

    task automatic test_random_views();
        int phase;
        for (phase = 0; phase < 4; phase++) begin
            drain_results();
            case (phase)
                0: set_traffic(0, 0, 1'b0);
                1: set_traffic(67, 0, 1'b0);
                2: set_traffic(0, 67, 1'b0);
                default: set_traffic(15, 15, 1'b0);
            endcase
            repeat (4) begin
                randomise_settings();
                repeat (25) send_random_pixel();
            end
        end
        drain_results();
        set_traffic(0, 0, 1'b0);
    endtask

    task automatic test_receiver_hold();
        configure(RST_VIEW_LEFT, RST_VIEW_TOP, RST_STEP_REAL, RST_STEP_IMAG,
                  RST_COLOR_SCL, 13'd24, RST_ESC_LIMIT);
        set_traffic(0, 0, 1'b1);
        repeat (20) send_random_pixel();
        drain_results();
        set_traffic(0, 0, 1'b0);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        set_left        = RST_VIEW_LEFT;
        set_top         = RST_VIEW_TOP;
        set_step_re     = RST_STEP_REAL;
        set_step_im     = RST_STEP_IMAG;
        set_color_scale = RST_COLOR_SCL;
        set_iter_max    = RST_ITER_MAX;
        set_escape_sq   = RST_ESC_LIMIT;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_view();
        test_iteration_limits();
        test_saturation();
        test_random_views();
        test_receiver_hold();

        drain_results();
        if (expected_pixels.size() != 0)
            report_failure($sformatf("%0d results never arrived", expected_pixels.size()));
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
